[src/sttc_pkg.sv]
package sttc_pkg;

  localparam int LINE_MAX_DEFAULT = 4096;
  localparam int KEYWORD_MAX_LEN_DEFAULT = 12;
  localparam int KW_COUNT = 61;
  localparam int KW_TEXT_LEN = 11;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] CLS_DEFAULT  = 4'd0;
  localparam logic [3:0] CLS_KEYWORD  = 4'd1;
  localparam logic [3:0] CLS_CCOMMENT = 4'd2;
  localparam logic [3:0] CLS_LCOMMENT = 4'd3;
  localparam logic [3:0] CLS_IDENT    = 4'd4;
  localparam logic [3:0] CLS_NUMBER   = 4'd5;
  localparam logic [3:0] CLS_CHAR     = 4'd6;
  localparam logic [3:0] CLS_STRING   = 4'd7;
  localparam logic [3:0] CLS_PREPROC  = 4'd8;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       line_has_include;
  } item_t;

  typedef struct packed {
    logic [11:0] span_start;
    logic [3:0]  span_length;
    logic        to_end_of_line;
    logic [3:0]  token_class;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } bundle_t;

  typedef struct packed {
    logic [3:0]              len;
    logic [8*KW_TEXT_LEN-1:0] text;
  } kw_entry_t;

  function automatic kw_entry_t kw_rom(input int k);
    kw_entry_t e;
    e = '0;
    case (k)
      0:  e = '{4'd1, "@"};
      1:  e = '{4'd8, "@foreign"};
      2:  e = '{4'd7, "@global"};
      3:  e = '{4'd5, "@hook"};
      4:  e = '{4'd6, "@ptask"};
      5:  e = '{4'd7, "@remote"};
      6:  e = '{4'd7, "@return"};
      7:  e = '{4'd5, "@task"};
      8:  e = '{4'd5, "@test"};
      9:  e = '{4'd6, "@timer"};
      10: e = '{4'd1, "_"};
      11: e = '{4'd11, "__addressof"};
      12: e = '{4'd6, "__emit"};
      13: e = '{4'd8, "__nameof"};
      14: e = '{4'd8, "__pragma"};
      15: e = '{4'd6, "assert"};
      16: e = '{4'd5, "break"};
      17: e = '{4'd4, "case"};
      18: e = '{4'd4, "char"};
      19: e = '{4'd5, "const"};
      20: e = '{4'd8, "continue"};
      21: e = '{4'd4, "decl"};
      22: e = '{4'd7, "default"};
      23: e = '{4'd5, "defer"};
      24: e = '{4'd7, "defined"};
      25: e = '{4'd2, "do"};
      26: e = '{4'd4, "else"};
      27: e = '{4'd4, "enum"};
      28: e = '{4'd4, "exit"};
      29: e = '{4'd5, "false"};
      30: e = '{4'd5, "final"};
      31: e = '{4'd3, "for"};
      32: e = '{4'd7, "foreach"};
      33: e = '{4'd7, "foreign"};
      34: e = '{4'd7, "forward"};
      35: e = '{4'd6, "global"};
      36: e = '{4'd4, "goto"};
      37: e = '{4'd2, "if"};
      38: e = '{4'd6, "inline"};
      39: e = '{4'd4, "hook"};
      40: e = '{4'd6, "native"};
      41: e = '{4'd3, "new"};
      42: e = '{4'd8, "operator"};
      43: e = '{4'd5, "ptask"};
      44: e = '{4'd6, "public"};
      45: e = '{4'd6, "repeat"};
      46: e = '{4'd6, "return"};
      47: e = '{4'd6, "sizeof"};
      48: e = '{4'd5, "sleep"};
      49: e = '{4'd5, "state"};
      50: e = '{4'd6, "static"};
      51: e = '{4'd5, "stock"};
      52: e = '{4'd4, "stop"};
      53: e = '{4'd6, "switch"};
      54: e = '{4'd5, "tagof"};
      55: e = '{4'd4, "task"};
      56: e = '{4'd5, "timer"};
      57: e = '{4'd4, "true"};
      58: e = '{4'd5, "using"};
      59: e = '{4'd5, "while"};
      60: e = '{4'd5, "yield"};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[src/sttc_front.sv]
module sttc_front #(
  parameter int LINE_MAX = sttc_pkg::LINE_MAX_DEFAULT,
  parameter int KEYWORD_MAX_LEN = sttc_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sttc_pkg::item_t   item,
  output logic              full,
  input  logic              q_full,
  output logic              q_push,
  output sttc_pkg::bundle_t q_data
);

  localparam int CW = $clog2(LINE_MAX);
  localparam int LW = $clog2(KEYWORD_MAX_LEN + 1);
  localparam int IW = $clog2(KEYWORD_MAX_LEN);
  localparam int DW = ((CW > LW) ? CW : LW) + 1;
  localparam logic [CW-1:0] COL_LAST = CW'(LINE_MAX - 1);

  typedef enum logic [9:0] {
    M_UNKNOWN = 10'b0000000001,
    M_CBEGIN  = 10'b0000000010,
    M_COMMENT = 10'b0000000100,
    M_CEND    = 10'b0000001000,
    M_IDENT   = 10'b0000010000,
    M_NUMBER  = 10'b0000100000,
    M_CHAR    = 10'b0001000000,
    M_STRING  = 10'b0010000000,
    M_PREPROC = 10'b0100000000,
    M_PPNEXT  = 10'b1000000000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       hit;
    logic       eol;
    logic [3:0] cls;
    logic       skip;
  } neutral_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == 8'hAA || c == 8'hB5 ||
           c == 8'hBA || (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
  endfunction

  function automatic logic is_ident_first(input logic [7:0] c);
    return is_letter(c) || c == "_" || c == "@";
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_ident_first(c) || is_digit(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == "x";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'h85 || c == 8'hA0;
  endfunction

  function automatic neutral_t neutral(input logic [7:0] c, input logic inc);
    neutral_t r;
    r = '{M_UNKNOWN, 1'b0, 1'b0, sttc_pkg::CLS_DEFAULT, 1'b0};
    if (c == "'") begin
      r = '{M_CHAR, 1'b1, 1'b0, sttc_pkg::CLS_CHAR, 1'b0};
    end else if (is_ident_first(c)) begin
      r = '{M_IDENT, 1'b1, 1'b0, sttc_pkg::CLS_IDENT, 1'b0};
    end else if (is_digit(c)) begin
      r = '{M_NUMBER, 1'b1, 1'b0, sttc_pkg::CLS_NUMBER, 1'b0};
    end else if (c == "/") begin
      r.mode = M_CBEGIN;
    end else if (c == "\"") begin
      r = '{M_STRING, 1'b1, 1'b0, sttc_pkg::CLS_STRING, 1'b0};
    end else if (c == "#") begin
      r = '{M_PREPROC, 1'b1, 1'b0, sttc_pkg::CLS_PREPROC, 1'b0};
    end else if (c == "<" && inc) begin
      r = '{M_UNKNOWN, 1'b1, 1'b1, sttc_pkg::CLS_STRING, 1'b1};
    end
    return r;
  endfunction

  mode_t mode, mode_next;
  logic [CW-1:0] col, col_next;
  logic skip, skip_next;
  logic [LW-1:0] rlen, rlen_next;
  logic rlong, rlong_next;
  logic [7:0] run [KEYWORD_MAX_LEN];

  logic kw_match;
  logic kw_hit;
  logic m_hit;
  logic [CW-1:0] m_start;
  logic [1:0] m_len;
  logic m_eol;
  logic [3:0] m_cls;
  logic [CW-1:0] col_m1;
  logic [DW-1:0] kw_diff;
  logic [CW-1:0] kw_start;
  logic accept;
  neutral_t nb;
  sttc_pkg::result_t kw_res, m_res;

  assign full = q_full;
  assign accept = push && !q_full;
  assign col_m1 = (col == '0) ? '0 : col - CW'(1);

  // keyword rom compare against the run before this item
  always_comb begin
    logic eq;
    sttc_pkg::kw_entry_t e;
    int idx;
    kw_match = 1'b0;
    for (int k = 0; k < sttc_pkg::KW_COUNT; k++) begin
      e = sttc_pkg::kw_rom(k);
      eq = (int'(rlen) == int'(e.len));
      for (int i = 0; i < sttc_pkg::KW_TEXT_LEN; i++) begin
        idx = (i < int'(e.len)) ? (int'(e.len) - 1 - i) : 0;
        if (i < int'(e.len) && run[i] != e.text[8*idx +: 8]) begin
          eq = 1'b0;
        end
      end
      if (eq && !rlong && rlen != '0) begin
        kw_match = 1'b1;
      end
    end
  end

  assign kw_diff = DW'(col) - DW'(rlen);
  assign kw_start = (DW'(rlen) > DW'(col)) ? '0 : kw_diff[CW-1:0];

  always_comb begin
    mode_next = mode;
    skip_next = skip;
    col_next = col;
    rlen_next = rlen;
    rlong_next = rlong;
    kw_hit = 1'b0;
    m_hit = 1'b0;
    m_start = col;
    m_len = 2'd1;
    m_eol = 1'b0;
    m_cls = sttc_pkg::CLS_DEFAULT;
    nb = neutral(item.ch, item.line_has_include);
    if (item.cmd == sttc_pkg::CMD_EOL) begin
      kw_hit = (mode == M_IDENT) && kw_match;
      case (mode)
        M_COMMENT, M_CEND, M_STRING: mode_next = mode;
        M_PPNEXT: mode_next = M_PREPROC;
        default: mode_next = M_UNKNOWN;
      endcase
      col_next = '0;
      skip_next = 1'b0;
      rlen_next = '0;
      rlong_next = 1'b0;
    end else begin
      if (!skip) begin
        case (mode)
          M_COMMENT: begin
            if (item.ch == "*") mode_next = M_CEND;
            m_hit = 1'b1;
            m_cls = sttc_pkg::CLS_CCOMMENT;
          end
          M_CBEGIN: begin
            if (item.ch == "/") begin
              m_hit = 1'b1;
              m_start = col_m1;
              m_len = 2'd0;
              m_eol = 1'b1;
              m_cls = sttc_pkg::CLS_LCOMMENT;
              skip_next = 1'b1;
            end else if (item.ch == "*") begin
              m_hit = 1'b1;
              m_start = col_m1;
              m_len = 2'd2;
              m_cls = sttc_pkg::CLS_CCOMMENT;
              mode_next = M_COMMENT;
            end else begin
              mode_next = M_UNKNOWN;
            end
          end
          M_CEND: begin
            m_hit = 1'b1;
            m_cls = sttc_pkg::CLS_CCOMMENT;
            mode_next = (item.ch == "/") ? M_UNKNOWN : (item.ch == "*") ? M_CEND : M_COMMENT;
          end
          M_IDENT: begin
            if (is_ident(item.ch)) begin
              m_hit = 1'b1;
              m_cls = sttc_pkg::CLS_IDENT;
            end else begin
              kw_hit = kw_match;
              mode_next = nb.mode;
              m_hit = nb.hit;
              m_len = nb.eol ? 2'd0 : 2'd1;
              m_eol = nb.eol;
              m_cls = nb.cls;
              if (nb.skip) skip_next = 1'b1;
            end
          end
          M_NUMBER: begin
            if (is_hex(item.ch) || item.ch == "." || item.ch == "_") begin
              m_hit = 1'b1;
              m_cls = sttc_pkg::CLS_NUMBER;
            end else begin
              mode_next = nb.mode;
              m_hit = nb.hit;
              m_len = nb.eol ? 2'd0 : 2'd1;
              m_eol = nb.eol;
              m_cls = nb.cls;
              if (nb.skip) skip_next = 1'b1;
            end
          end
          M_CHAR: begin
            m_hit = 1'b1;
            m_cls = sttc_pkg::CLS_CHAR;
            if (item.ch == "'") mode_next = M_UNKNOWN;
          end
          M_STRING: begin
            m_hit = 1'b1;
            m_cls = sttc_pkg::CLS_STRING;
            if (item.ch == "\"") mode_next = M_UNKNOWN;
          end
          M_PREPROC: begin
            if (item.ch == "\\") begin
              mode_next = M_PPNEXT;
              skip_next = 1'b1;
            end else if (is_space(item.ch)) begin
              mode_next = M_UNKNOWN;
            end else begin
              m_hit = 1'b1;
              m_cls = sttc_pkg::CLS_PREPROC;
            end
          end
          M_PPNEXT: mode_next = mode;
          default: begin
            mode_next = nb.mode;
            m_hit = nb.hit;
            m_len = nb.eol ? 2'd0 : 2'd1;
            m_eol = nb.eol;
            m_cls = nb.cls;
            if (nb.skip) skip_next = 1'b1;
          end
        endcase
      end
      if (is_ident(item.ch)) begin
        if (int'(rlen) < KEYWORD_MAX_LEN) begin
          rlen_next = rlen + LW'(1);
        end else begin
          rlong_next = 1'b1;
        end
      end else begin
        rlen_next = '0;
        rlong_next = 1'b0;
      end
      if (col < COL_LAST) col_next = col + CW'(1);
    end
  end

  always_comb begin
    kw_res = '{12'(kw_start), 4'(rlen), 1'b0, sttc_pkg::CLS_KEYWORD, !m_hit};
    m_res = '{12'(m_start), 4'(m_len), m_eol, m_cls, 1'b1};
    q_push = accept && (kw_hit || m_hit);
    q_data.two = kw_hit && m_hit;
    q_data.first = kw_hit ? kw_res : m_res;
    q_data.second = m_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_UNKNOWN;
      col <= '0;
      skip <= 1'b0;
      rlen <= '0;
      rlong <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      col <= col_next;
      skip <= skip_next;
      rlen <= rlen_next;
      rlong <= rlong_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd == sttc_pkg::CMD_BYTE && is_ident(item.ch) &&
        int'(rlen) < KEYWORD_MAX_LEN) begin
      run[rlen[IW-1:0]] <= item.ch;
    end
  end

endmodule

[src/sttc_queue.sv]
module sttc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  sttc_pkg::bundle_t wr_data,
  output logic              q_full,
  input  logic              rd,
  output logic              q_empty,
  output sttc_pkg::bundle_t rd_data
);

  localparam int PW = $clog2(sttc_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(sttc_pkg::QUEUE_DEPTH + 1);

  sttc_pkg::bundle_t entries [sttc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [NW-1:0] count;
  logic do_wr, do_rd;

  assign q_full = (int'(count) == sttc_pkg::QUEUE_DEPTH);
  assign q_empty = (count == '0);
  assign do_wr = wr && !q_full;
  assign do_rd = rd && !q_empty;
  assign rd_data = entries[rp];

  always_ff @(posedge clk) begin
    if (do_wr) entries[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= PW'((int'(wp) + 1) % sttc_pkg::QUEUE_DEPTH);
      if (do_rd) rp <= PW'((int'(rp) + 1) % sttc_pkg::QUEUE_DEPTH);
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

[src/sttc_back.sv]
module sttc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  sttc_pkg::bundle_t head,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output sttc_pkg::result_t result
);

  logic out_valid;
  logic sub;
  logic load;
  sttc_pkg::result_t out_reg;

  assign load = (!out_valid || pop) && !q_empty;
  assign q_pop = load && (sub || !head.two);
  assign empty = !out_valid;
  assign result = out_reg;

  always_ff @(posedge clk) begin
    if (load) out_reg <= sub ? head.second : head.first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub <= !(sub || !head.two);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/source_text_token_classifier_unit.sv]
// path: an accepted item's results go through the queue into the output register
// throughput: one item per cycle while full is low; one result out per cycle
//   while pop is held, so two-result items are absorbed by a four-entry queue
// reset: rst is synchronous, active high; clears lexer mode, column, run state
//   and empties the queue and output register
module source_text_token_classifier_unit #(
  parameter int LINE_MAX = sttc_pkg::LINE_MAX_DEFAULT,
  parameter int KEYWORD_MAX_LEN = sttc_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  sttc_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output sttc_pkg::result_t result
);

  logic q_full, q_empty, q_push, q_pop;
  sttc_pkg::bundle_t q_data, head;

  sttc_front #(
    .LINE_MAX(LINE_MAX),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .full(full),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_data)
  );

  sttc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr(q_push),
    .wr_data(q_data),
    .q_full(q_full),
    .rd(q_pop),
    .q_empty(q_empty),
    .rd_data(head)
  );

  sttc_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .head(head),
    .q_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

endmodule

[tb/sv/tb.sv]
module tb;

  localparam int COL_TOP = sttc_pkg::LINE_MAX_DEFAULT - 1;
  localparam int RUN_MAX = sttc_pkg::KEYWORD_MAX_LEN_DEFAULT;
  localparam logic [3:0] MODE_UNKNOWN = 4'd0;
  localparam logic [3:0] MODE_CBEGIN  = 4'd1;
  localparam logic [3:0] MODE_COMMENT = 4'd2;
  localparam logic [3:0] MODE_CEND    = 4'd3;
  localparam logic [3:0] MODE_IDENT   = 4'd4;
  localparam logic [3:0] MODE_NUMBER  = 4'd5;
  localparam logic [3:0] MODE_CHAR    = 4'd6;
  localparam logic [3:0] MODE_STRING  = 4'd7;
  localparam logic [3:0] MODE_PREPROC = 4'd8;
  localparam logic [3:0] MODE_PPNEXT  = 4'd9;

  class span_scoreboard;
    sttc_pkg::result_t pending[$];
    logic [3:0] mode;
    int col;
    bit skip;
    logic [7:0] run[RUN_MAX];
    int run_len;
    bit run_long;
    int errors;
    int checked;
    sttc_pkg::result_t fresh[$];

    function void clear();
      mode = MODE_UNKNOWN;
      col = 0;
      skip = 0;
      run_len = 0;
      run_long = 0;
    endfunction

    function bit letter(logic [7:0] c);
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return 1;
      if (c == 8'hAA || c == 8'hB5 || c == 8'hBA) return 1;
      return c >= 8'hC0 && c != 8'hD7 && c != 8'hF7;
    endfunction

    function bit ident_first(logic [7:0] c);
      return letter(c) || c == "_" || c == "@";
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit ident(logic [7:0] c);
      return ident_first(c) || digit(c);
    endfunction

    function bit hexch(logic [7:0] c);
      return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == "x";
    endfunction

    function bit space(logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'h85 || c == 8'hA0;
    endfunction

    function void add(int start, int len, bit eol, logic [3:0] cls);
      sttc_pkg::result_t r;
      r.span_start = start[11:0];
      r.span_length = len[3:0];
      r.to_end_of_line = eol;
      r.token_class = cls;
      r.last = 1'b0;
      fresh.push_back(r);
    endfunction

    // own keyword table, compared as strings
    function bit kw_hit();
      string kws[61] = '{"@", "@foreign", "@global", "@hook", "@ptask", "@remote",
        "@return", "@task", "@test", "@timer", "_", "__addressof", "__emit",
        "__nameof", "__pragma", "assert", "break", "case", "char", "const",
        "continue", "decl", "default", "defer", "defined", "do", "else", "enum",
        "exit", "false", "final", "for", "foreach", "foreign", "forward",
        "global", "goto", "if", "inline", "hook", "native", "new", "operator",
        "ptask", "public", "repeat", "return", "sizeof", "sleep", "state",
        "static", "stock", "stop", "switch", "tagof", "task", "timer", "true",
        "using", "while", "yield"};
      string s;
      if (run_long || run_len == 0) return 0;
      s = "";
      for (int i = 0; i < run_len; i++) s = {s, string'(run[i])};
      foreach (kws[k]) if (kws[k] == s) return 1;
      return 0;
    endfunction

    function void keyword_span(int c0);
      if (kw_hit()) add(run_len > c0 ? 0 : c0 - run_len, run_len, 0, sttc_pkg::CLS_KEYWORD);
    endfunction

    function void neutral(logic [7:0] c, int c0, bit inc);
      mode = MODE_UNKNOWN;
      if (c == "'") begin
        mode = MODE_CHAR;
        add(c0, 1, 0, sttc_pkg::CLS_CHAR);
      end else if (ident_first(c)) begin
        mode = MODE_IDENT;
        add(c0, 1, 0, sttc_pkg::CLS_IDENT);
      end else if (digit(c)) begin
        mode = MODE_NUMBER;
        add(c0, 1, 0, sttc_pkg::CLS_NUMBER);
      end else if (c == "/") begin
        mode = MODE_CBEGIN;
      end else if (c == "\"") begin
        mode = MODE_STRING;
        add(c0, 1, 0, sttc_pkg::CLS_STRING);
      end else if (c == "#") begin
        mode = MODE_PREPROC;
        add(c0, 1, 0, sttc_pkg::CLS_PREPROC);
      end else if (c == "<" && inc) begin
        add(c0, 0, 1, sttc_pkg::CLS_STRING);
        skip = 1;
      end
    endfunction

    function void note_item(sttc_pkg::item_t it);
      int c0;
      logic [7:0] c;
      c0 = col;
      c = it.ch;
      fresh.delete();
      if (it.cmd == sttc_pkg::CMD_EOL) begin
        if (mode == MODE_IDENT) keyword_span(c0);
        case (mode)
          MODE_COMMENT, MODE_CEND, MODE_STRING: ;
          MODE_PPNEXT: mode = MODE_PREPROC;
          default: mode = MODE_UNKNOWN;
        endcase
        col = 0;
        skip = 0;
        run_len = 0;
        run_long = 0;
      end else begin
        if (!skip) begin
          case (mode)
            MODE_COMMENT: begin
              if (c == "*") mode = MODE_CEND;
              add(c0, 1, 0, sttc_pkg::CLS_CCOMMENT);
            end
            MODE_CBEGIN: begin
              if (c == "/") begin
                add(c0 == 0 ? 0 : c0 - 1, 0, 1, sttc_pkg::CLS_LCOMMENT);
                skip = 1;
              end else if (c == "*") begin
                add(c0 == 0 ? 0 : c0 - 1, 2, 0, sttc_pkg::CLS_CCOMMENT);
                mode = MODE_COMMENT;
              end else mode = MODE_UNKNOWN;
            end
            MODE_CEND: begin
              add(c0, 1, 0, sttc_pkg::CLS_CCOMMENT);
              mode = (c == "/") ? MODE_UNKNOWN : (c == "*") ? MODE_CEND : MODE_COMMENT;
            end
            MODE_IDENT: begin
              if (ident(c)) add(c0, 1, 0, sttc_pkg::CLS_IDENT);
              else begin
                keyword_span(c0);
                neutral(c, c0, it.line_has_include);
              end
            end
            MODE_NUMBER: begin
              if (hexch(c) || c == "." || c == "_") add(c0, 1, 0, sttc_pkg::CLS_NUMBER);
              else neutral(c, c0, it.line_has_include);
            end
            MODE_CHAR: begin
              add(c0, 1, 0, sttc_pkg::CLS_CHAR);
              if (c == "'") mode = MODE_UNKNOWN;
            end
            MODE_STRING: begin
              add(c0, 1, 0, sttc_pkg::CLS_STRING);
              if (c == "\"") mode = MODE_UNKNOWN;
            end
            MODE_PREPROC: begin
              if (c == "\\") begin
                mode = MODE_PPNEXT;
                skip = 1;
              end else if (space(c)) mode = MODE_UNKNOWN;
              else add(c0, 1, 0, sttc_pkg::CLS_PREPROC);
            end
            MODE_PPNEXT: ;
            default: neutral(c, c0, it.line_has_include);
          endcase
        end
        if (ident(c)) begin
          if (run_len < RUN_MAX) begin
            run[run_len] = c;
            run_len++;
          end else run_long = 1;
        end else begin
          run_len = 0;
          run_long = 0;
        end
        if (col < COL_TOP) col++;
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) pending.push_back(fresh[i]);
    endfunction

    function void check_result(sttc_pkg::result_t got);
      sttc_pkg::result_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  sttc_pkg::item_t item = '0;
  logic full, empty;
  sttc_pkg::result_t result;
  span_scoreboard sb;
  int send_idle = 38;
  int recv_idle = 47;
  int cycles = 0;
  int lines = 0;

  always #5 clk = ~clk;

  source_text_token_classifier_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && pop && !empty) sb.check_result(result);
    if (!rst && push && !full) sb.note_item(item);
    if (cycles > 400000) begin
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) pop <= !rst && ($urandom_range(99) >= recv_idle);

  task automatic send(logic cmd, logic [7:0] c, logic inc);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= '{cmd: cmd, ch: c, line_has_include: inc};
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (cmd == sttc_pkg::CMD_EOL) lines++;
  endtask

  task automatic send_text(string s, logic inc);
    for (int i = 0; i < s.len(); i++) send(sttc_pkg::CMD_BYTE, s[i], inc);
    send(sttc_pkg::CMD_EOL, 8'($urandom), inc);
  endtask

  function automatic string random_line();
    string words[24] = '{"if", "while", "__addressof", "@foreign", "_", "@",
      "x1", "1if", "0x1F_a.b", "'a'", "\"str\"", "/* c */", "// rest", "#define",
      "#include <a.h>", "abcdefghijklm", "return", "/x", "*/", "a\\b", "foreach",
      "__emit", "#pp \\", "stock"};
    string seps[6] = '{" ", "(", ";", ",", "\t", ""};
    string s = "";
    int n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      s = {s, words[$urandom_range(23)], seps[$urandom_range(5)]};
      if ($urandom_range(9) == 0) s = {s, string'(8'($urandom))};
    end
    return s;
  endfunction

  task automatic random_phase(int count);
    int done = 0;
    while (done < count) begin
      if ($urandom_range(4) == 0) begin
        int n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) send(sttc_pkg::CMD_BYTE, 8'($urandom), 1'($urandom));
        send(sttc_pkg::CMD_EOL, 8'($urandom), 1'($urandom));
        done += n + 1;
      end else begin
        string s = random_line();
        send_text(s, 1'($urandom_range(1)));
        done += s.len() + 1;
      end
    end
  endtask

  initial begin
    int wait_cnt;
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed lines
    send_text("if @ __addressof x", 1'b0);
    send_text("#include <x> 1if", 1'b1);
    send_text("/* a */ // b", 1'b0);
    send_text("#a\\", 1'b0);
    send_text("b 'c' \"s\"", 1'b0);
    send(sttc_pkg::CMD_BYTE, 8'hFF, 1'b1);
    send(sttc_pkg::CMD_BYTE, 8'h00, 1'b0);
    send_text("abcdefghijklmif /q", 1'b0);
    random_phase(420);
    send_idle = 47;
    recv_idle = 38;
    random_phase(420);
    send_idle = 0;
    recv_idle = 0;
    random_phase(400);
    push <= 1'b0;
    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d lines, %0d results checked", lines, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

[source_text_token_classifier_unit.f]
src/sttc_pkg.sv
src/sttc_front.sv
src/sttc_queue.sv
src/sttc_back.sv
src/source_text_token_classifier_unit.sv
tb/sv/tb.sv
